>>> rtl/core/rv32s_pkg.sv
package rv32s_pkg;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_CUSTOM = 7'b1111110;

    localparam logic [31:0] HALT_WORD       = 32'h0000_0063;
    localparam logic [31:0] SP_RESET        = 32'd256;
    localparam logic [31:0] DATA_BASE_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        wb_enable;
        logic [4:0]  wb_index;
        logic [31:0] wb_value;
        logic        regs_cleared;
        logic        store_enable;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic        address_fault;
        logic        halted;
    } t_result;

endpackage

>>> rtl/core/rv32i_subset_executor.sv
// rv32i subset executor: each accepted instruction item is executed in
// the cycle it is accepted against the pc, register file (x2 resets to
// 256) and a DATA_WORDS-word data memory at the base address; the result
// item appears in the output register in the next cycle. one item per
// clock is sustained unless the output stalls; the register file and data
// memory update in the accepting cycle for the next item. the halt word
// freezes pc, registers and memory; later items report halted, pc kept.
module rv32i_subset_executor #(
    parameter int DATA_WORDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_next_pc,
    output logic        o_wb_enable,
    output logic [4:0]  o_wb_index,
    output logic [31:0] o_wb_value,
    output logic        o_regs_cleared,
    output logic        o_store_enable,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_store_data,
    output logic        o_address_fault,
    output logic        o_halted
);
    import rv32s_pkg::*;

    localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

    logic [31:0] r_pc, r_base;
    logic        r_halt;
    logic [31:0] r_mem [DATA_WORDS];
    logic        r_ovalid;
    t_result     r_out, n_out;

    // accept when output slot is free or being drained
    logic take;
    assign o_stall     = r_ovalid && i_stall;
    assign take        = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // decode fields
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [4:0] rd;
    assign op = i_instr[6:0];
    assign f3 = i_instr[14:12];
    assign f7 = i_instr[31:25];
    assign rd = i_instr[11:7];

    logic [31:0] a, b;
    logic        rf_we, rf_clear;
    logic [31:0] rf_wd;

    rv32s_regfile u_rf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rs1      (i_instr[19:15]),
        .i_rs2      (i_instr[24:20]),
        .o_rs1_data (a),
        .o_rs2_data (b),
        .i_we       (rf_we),
        .i_wa       (rd),
        .i_wd       (rf_wd),
        .i_clear    (rf_clear)
    );

    logic [31:0] imm_i, imm_s, imm_b, imm_j, addr, off;
    assign imm_i = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imm_s = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign imm_b = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                    i_instr[11:8], 1'b0};
    assign imm_j = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                    i_instr[30:21], 1'b0};
    assign addr  = a + ((op == OP_STORE) ? imm_s : imm_i);
    assign off   = addr - r_base;

    // window check: word aligned and word index below depth
    logic        in_win;
    logic [AW-1:0] widx;
    assign in_win = (off[1:0] == 2'b00) && ({2'b00, off[31:2]} < 32'(DATA_WORDS));
    assign widx   = AW'(off[31:2]);

    logic [31:0] ld_word;
    assign ld_word = r_mem[widx];

    logic signed [31:0] as, bs;
    assign as = a;
    assign bs = b;

    logic [31:0] rev;
    always_comb begin
        for (int i = 0; i < 32; i++) rev[i] = a[31-i];
    end

    logic [31:0] prod;
    assign prod = a * b;

    logic        wr, st, halt_now, take_br;
    logic [31:0] val, npc;

    always_comb begin
        wr       = 1'b0;
        st       = 1'b0;
        val      = 32'd0;
        npc      = r_pc + 32'd4;
        rf_clear = 1'b0;
        take_br  = 1'b0;
        n_out    = '0;
        halt_now = r_halt || (i_instr == HALT_WORD);
        unique case (op)
            OP_REG: begin
                wr = 1'b1;
                case (f3)
                    3'd0: begin
                        if (f7 == 7'b0000000) val = a + b;
                        else if (f7 == 7'b0100000) val = a - b;
                        else wr = 1'b0;
                    end
                    3'd1: val = a << b[4:0];
                    3'd2: val = {31'd0, as < bs};
                    3'd3: val = {31'd0, a < b};
                    3'd4: val = a ^ b;
                    3'd5: val = a >> b[4:0];
                    3'd6: val = a | b;
                    default: val = a & b;
                endcase
            end
            OP_LOAD: if (f3 == 3'd2) begin
                wr = 1'b1;
                val = in_win ? ld_word : 32'd0;
                n_out.mem_address = addr;
                n_out.address_fault = !in_win;
            end
            OP_IMM: begin
                if (f3 == 3'd0) begin
                    wr = 1'b1; val = a + imm_i;
                end else if (f3 == 3'd3) begin
                    wr = 1'b1; val = {31'd0, a < imm_i};
                end
            end
            OP_JALR: if (f3 == 3'd0) begin
                wr = 1'b1; val = r_pc + 32'd4;
                npc = (a + imm_i) & ~32'd1;
            end
            OP_STORE: if (f3 == 3'd2) begin
                n_out.mem_address = addr;
                st = in_win;
                n_out.address_fault = !in_win;
                n_out.store_data = in_win ? b : 32'd0;
            end
            OP_BRANCH: if (f3 != 3'd2 && f3 != 3'd3) begin
                case (f3)
                    3'd0: take_br = (a == b);
                    3'd1: take_br = (a != b);
                    3'd4: take_br = (as < bs);
                    3'd5: take_br = !(as < bs);
                    3'd6: take_br = (a < b);
                    default: take_br = (a >= b);
                endcase
                if (take_br) npc = r_pc + imm_b;
            end
            OP_JAL: begin
                wr = 1'b1; val = r_pc + 32'd4; npc = r_pc + imm_j;
            end
            OP_LUI: begin
                wr = 1'b1; val = {i_instr[31:12], 12'd0};
            end
            OP_AUIPC: begin
                wr = 1'b1; val = r_pc + {i_instr[31:12], 12'd0};
            end
            OP_CUSTOM: begin
                case (f3)
                    3'd0: rf_clear = 1'b1;
                    3'd1: begin wr = 1'b1; val = rev; end
                    3'd2: begin wr = 1'b1; val = prod; end
                    default: ;
                endcase
            end
            default: ;
        endcase
        n_out.next_pc      = npc;
        n_out.regs_cleared = rf_clear;
        n_out.store_enable = st;
        if (wr && rd != 5'd0) begin
            n_out.wb_enable = 1'b1;
            n_out.wb_index  = rd;
            n_out.wb_value  = val;
        end
        if (halt_now) begin
            n_out = '0;
            n_out.next_pc = r_pc;
            n_out.halted  = 1'b1;
            rf_clear = 1'b0;
            st = 1'b0;
        end
        rf_we = take && n_out.wb_enable;
        rf_wd = val;
        if (!take) rf_clear = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= 32'd0;
            r_halt   <= 1'b0;
            r_base   <= DATA_BASE_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_base <= i_cfg_data;
            if (take) begin
                r_pc   <= n_out.next_pc;
                r_halt <= halt_now;
            end
            if (take) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_out <= n_out;
    end

    // data memory, reset clears every word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DATA_WORDS; i++) r_mem[i] <= 32'd0;
        end else if (take && st) begin
            r_mem[widx] <= b;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_next_pc       = r_out.next_pc;
    assign o_wb_enable     = r_out.wb_enable;
    assign o_wb_index      = r_out.wb_index;
    assign o_wb_value      = r_out.wb_value;
    assign o_regs_cleared  = r_out.regs_cleared;
    assign o_store_enable  = r_out.store_enable;
    assign o_mem_address   = r_out.mem_address;
    assign o_store_data    = r_out.store_data;
    assign o_address_fault = r_out.address_fault;
    assign o_halted        = r_out.halted;
endmodule

>>> rtl/core/rv32s_regfile.sv
module rv32s_regfile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_rs1,
    input  logic [4:0]  i_rs2,
    output logic [31:0] o_rs1_data,
    output logic [31:0] o_rs2_data,
    input  logic        i_we,
    input  logic [4:0]  i_wa,
    input  logic [31:0] i_wd,
    input  logic        i_clear
);
    import rv32s_pkg::*;

    logic [31:0] r_regs [32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < 32; i++) begin
                r_regs[i] <= (i == 2 && !i_rst_n) ? SP_RESET : 32'd0;
            end
        end else if (i_we && i_wa != 5'd0) begin
            r_regs[i_wa] <= i_wd;
        end
    end

    assign o_rs1_data = (i_rs1 == 5'd0) ? 32'd0 : r_regs[i_rs1];
    assign o_rs2_data = (i_rs2 == 5'd0) ? 32'd0 : r_regs[i_rs2];
endmodule
